>>> hw/rtl/sci_pkg.sv
// Package: sizes, state encoding and payload types of the setpoint curve interpolator
package sci_pkg;
	localparam int NumCurves = 16;
	localparam int MaxPoints = 16;
	localparam int CurveW = 4;
	localparam int PointW = 4;
	localparam int CountW = 5;
	localparam int AddrW = CurveW + PointW;
	localparam int DataW = 32;
	localparam int DivW = 64;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic ST_OK = 1'b0;
	localparam logic ST_EMPTY = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [3:0]        table_id;
		logic [3:0]        point_index;
		logic signed [31:0] x_value;
		logic signed [31:0] upper_value;
		logic signed [31:0] lower_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] upper_result;
		logic signed [31:0] lower_result;
		logic               status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CMP, S_HOLD, S_MUL, S_DIV, S_FIN, S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [DivW-1:0] num;
		logic [DataW-1:0] den;
	} div_req_t;
endpackage

>>> hw/rtl/sci_if.sv
// Interface: valid/ready channel carrying one payload
interface sci_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/setpoint_curve_interpolator_top.sv
// Top level: setpoint curve store with segment search and linear interpolation
//  channel | dir | payload
//  req     | in  | req_type, table_id, point_index, x_value, upper_value, lower_value
//  rsp     | out | upper_result, lower_result, status
// A load or an empty query goes from the read state straight to the output; any other
// query fetches the first point, then scans one segment at a time, and interpolates each
// limit when x falls inside a segment (multiply, serial divide, round and clamp).
// Point memory reads are registered; counts reset to zero, points do not.
// One item at a time; a finished result waits until the output register is free.
module setpoint_curve_interpolator_top (
	input logic clk,
	input logic arst_n,
	sci_if.sink   req,
	sci_if.source rsp
);
	import sci_pkg::*;

	logic [DataW*3-1:0] mem [NumCurves*MaxPoints];
	logic [DataW*3-1:0] rd_s1;
	logic [CountW-1:0] cnt_q [NumCurves];

	state_t st_q, st_d;
	req_t r_q;
	logic [CountW-1:0] n_q;
	logic [PointW-1:0] i_q;
	logic [DataW*3-1:0] pa_q;
	logic first_q;
	logic side_q;
	logic signed [DataW-1:0] res_up_q;
	logic [DivW-1:0] prod_q;
	logic [DataW-1:0] dx_q;
	logic neg_q;
	logic signed [DataW-1:0] y1_q;
	rsp_t res_q;
	rsp_t out_q;
	logic ovalid_q;

	logic signed [DataW-1:0] xa, xb, xq;
	logic [AddrW-1:0] rd_addr;
	logic rd_en;
	logic [PointW-1:0] rd_idx;
	logic last_seg;
	logic in_rng;
	logic hold_out;
	logic hold_lerp;
	logic [DataW*3-1:0] hold_pt;
	logic lane_lo;
	div_req_t dreq;
	logic ddone;
	logic [DivW-1:0] dquot;
	logic signed [DataW:0] dy;
	logic [DataW:0] mag;
	logic [DataW-1:0] tpos;
	logic signed [DataW+1:0] rsum;
	logic signed [DataW-1:0] rclamp;
	logic signed [DataW-1:0] ya_sel, yb_sel;

	sci_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quot(dquot));

	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = ovalid_q;
	assign rsp.data = out_q;

	assign xq = r_q.x_value;
	assign xa = pa_q[DataW*3-1 -: DataW];
	assign xb = rd_s1[DataW*3-1 -: DataW];
	assign last_seg = ({1'b0, i_q} + 5'd1 == n_q);
	assign in_rng = (xq >= xa) && (xq <= xb);
	assign lane_lo = (st_q == S_FIN);
	assign ya_sel = lane_lo ? pa_q[DataW-1:0] : pa_q[DataW*2-1 -: DataW];
	assign yb_sel = lane_lo ? rd_s1[DataW-1:0] : rd_s1[DataW*2-1 -: DataW];
	assign dy = 33'(yb_sel) - 33'(ya_sel);
	assign mag = dy[DataW] ? 33'(-dy) : 33'(dy);
	assign tpos = 32'(xq - xa);
	assign rsum = neg_q ? 34'(y1_q) - 34'(dquot) : 34'(y1_q) + 34'(dquot);
	assign rclamp = (rsum > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
		(rsum < -34'sh080000000) ? -32'sh80000000 : 32'(rsum);

	always_comb begin
		hold_out = 1'b0;
		hold_lerp = 1'b0;
		hold_pt = rd_s1;
		if (first_q) begin
			hold_out = (n_q == 5'd1);
		end else if (i_q == 4'd1 && xq <= xa) begin
			hold_out = 1'b1;
			hold_pt = pa_q;
		end else if (last_seg && xq >= xb) begin
			hold_out = 1'b1;
		end else if (in_rng && xa == xb) begin
			hold_out = 1'b1;
			hold_pt = pa_q;
		end else if (in_rng) begin
			hold_lerp = 1'b1;
		end else if (last_seg) begin
			hold_out = 1'b1;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (req.valid) st_d = S_RD;
			S_RD: begin
				if (r_q.req_type == REQ_LOAD || cnt_q[r_q.table_id] == '0) st_d = S_OUT;
				else st_d = S_CMP;
			end
			S_CMP: st_d = S_HOLD;
			S_HOLD: st_d = hold_out ? S_OUT : (hold_lerp ? S_MUL : S_CMP);
			S_MUL: st_d = S_DIV;
			S_DIV: if (ddone) st_d = S_FIN;
			S_FIN: st_d = side_q ? S_OUT : S_MUL;
			S_OUT: if (!ovalid_q || rsp.ready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en = (st_q == S_CMP);
		rd_idx = first_q ? '0 : i_q;
		rd_addr = {r_q.table_id, rd_idx};
		dreq.start = (st_q == S_MUL);
		dreq.num = prod_q + 64'(dx_q >> 1);
		dreq.den = dx_q;
	end

	always_ff @(posedge clk) begin
		if (st_q == S_RD && r_q.req_type == REQ_LOAD)
			mem[{r_q.table_id, r_q.point_index}] <=
				{r_q.x_value, r_q.upper_value, r_q.lower_value};
		if (rd_en) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ovalid_q <= 1'b0;
			for (int k = 0; k < NumCurves; k++) cnt_q[k] <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == S_HOLD) begin
				if (hold_out) begin
					res_q <= '{hold_pt[DataW*2-1 -: DataW], hold_pt[DataW-1:0], ST_OK};
				end else if (hold_lerp) begin
					side_q <= 1'b0;
					dx_q <= 32'(xb - xa);
				end else begin
					pa_q <= rd_s1;
					first_q <= 1'b0;
					if (!first_q) i_q <= i_q + 4'd1;
				end
			end
			if (st_q == S_IDLE && req.valid) r_q <= req.data;
			if (st_q == S_RD) begin
				i_q <= 4'd1;
				first_q <= 1'b1;
				n_q <= cnt_q[r_q.table_id];
				res_q <= '{32'sd0, 32'sd0,
					(r_q.req_type == REQ_QUERY) ? ST_EMPTY : ST_OK};
				if (r_q.req_type == REQ_LOAD)
					cnt_q[r_q.table_id] <= {1'b0, r_q.point_index} + 5'd1;
			end
			if (st_q == S_FIN) begin
				if (!side_q) begin
					res_up_q <= rclamp;
					side_q <= 1'b1;
				end else begin
					res_q <= '{res_up_q, rclamp, ST_OK};
				end
			end
			if (st_q == S_OUT && (!ovalid_q || rsp.ready)) begin
				ovalid_q <= 1'b1;
				out_q <= res_q;
			end else if (ovalid_q && rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == S_HOLD && hold_lerp) || st_q == S_FIN) begin
			prod_q <= 64'(tpos) * 64'(mag[DataW-1:0]);
			neg_q <= dy[DataW];
			y1_q <= ya_sel;
		end
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed while stalled");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second item taken while busy");
`endif
endmodule

>>> hw/rtl/sci_div.sv
// Module: restoring serial divider, one quotient bit per cycle
module sci_div (
	input  logic clk,
	input  logic arst_n,
	input  sci_pkg::div_req_t req,
	output logic done,
	output logic [sci_pkg::DivW-1:0] quot
);
	import sci_pkg::*;
	logic [DivW-1:0] q_q;
	logic [DataW:0] rem_q;
	logic [DataW-1:0] den_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [DataW:0] trial;
	logic [DataW+1:0] sh;

	assign sh = {rem_q, q_q[DivW-1]};
	assign trial = sh[DataW:0] - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DataW]) begin
				rem_q <= trial;
				q_q <= {q_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= sh[DataW:0];
				q_q <= {q_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule
